[sv/mrrc_pkg.sv]
// Package for the Modbus read-response checker: status codes, register
// indexes, sequencer states, CRC constants and the byte-wise CRC-16 update.
// No dependencies.
package mrrc_pkg;

  // Default depth of the word store.
  localparam int DEF_MAX_REGS = 32;

  // CRC-16 (Modbus) constants.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Reset values of the configuration registers.
  localparam logic [7:0] RST_DEVICE_ADDRESS     = 8'd1;
  localparam logic [7:0] RST_READ_FUNCTION_CODE = 8'd3;
  localparam logic [5:0] RST_REGISTER_COUNT     = 6'd19;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEVICE_ADDRESS     = 2'd0;
  localparam logic [1:0] REG_READ_FUNCTION_CODE = 2'd1;
  localparam logic [1:0] REG_REGISTER_COUNT     = 2'd2;

  // Check status codes carried in each result word.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd1;
  localparam logic [2:0] ST_BAD_FUNC  = 3'd2;
  localparam logic [2:0] ST_BAD_COUNT = 3'd3;
  localparam logic [2:0] ST_BAD_CRC   = 3'd4;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_ERR,
    S_READ,
    S_LOAD
  } mrrc_state_t;

  // One byte through the reflected CRC-16, one bit per step.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[sv/modbus_read_response_checker.sv]
// Top level of the Modbus RTU read-holding-registers response checker.
// Uses mrrc_pkg for codes, states and the CRC update.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------------
//   in      | to block  | in_valid / in_stall | rx_byte, frame_start
//   out     | from block| out_valid/out_stall | check_status, word_index, word_value,
//           |           |                     | last_result
//   cfg     | to block  | cfg_write           | cfg_index, cfg_data
//
// A byte that does not close a frame is taken whenever it is offered; the next byte
// may follow in the next cycle. After the closing byte the input is stalled for the
// result run: an error word is loaded from S_ERR, and each data word passes a store
// read (S_READ), then an output load (S_LOAD), before the next word is read.
// An output word held by out_stall holds the run. Reset (rst, synchronous) clears
// the control state and the configuration; the word store is not cleared.
module modbus_read_response_checker
  import mrrc_pkg::*;
#(
  parameter int MAX_REGS = DEF_MAX_REGS
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  // Output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  check_status,
  output logic [4:0]  word_index,
  output logic [15:0] word_value,
  output logic        last_result
);

  localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

  // Configuration registers.
  logic [7:0] device_address;
  logic [7:0] read_function_code;
  logic [5:0] register_count;

  // Frame state.
  mrrc_state_t state, state_next;
  logic        in_frame, in_frame_next;
  logic [6:0]  byte_position, byte_position_next;
  logic [15:0] running_crc, running_crc_next;
  logic [2:0]  first_error, first_error_next;
  logic [7:0]  held_byte, held_byte_next;

  // Result run state.
  logic [2:0]  final_status, final_status_next;
  logic [5:0]  run_count, run_count_next;
  logic [5:0]  word_ptr, word_ptr_next;

  // Output register next values.
  logic        out_valid_next;
  logic [2:0]  check_status_next;
  logic [4:0]  word_index_next;
  logic [15:0] word_value_next;
  logic        last_result_next;

  // Word store.
  logic [15:0] word_store [MAX_REGS];
  logic           store_we;
  logic [AW-1:0]  store_waddr;
  logic [15:0]    store_wdata;
  logic [AW-1:0]  store_raddr;
  logic [15:0]    store_rdata;

  // Per-byte decode.
  logic        accept;
  logic        slot_free;
  logic [5:0]  eff_count;
  logic [7:0]  frame_len;
  logic [6:0]  pos;
  logic [15:0] crc_cur;
  logic [2:0]  err_cur;
  logic [7:0]  pos_plus1;
  logic [7:0]  pos_plus2;
  logic [6:0]  word_slot;
  logic [15:0] rx_crc;
  logic [2:0]  close_status;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  // Register count clamped to 1..MAX_REGS, and the frame length from it.
  always_comb begin
    if (register_count == 6'd0) begin
      eff_count = 6'd1;
    end else if ({1'b0, register_count} > 7'(MAX_REGS)) begin
      eff_count = 6'(MAX_REGS);
    end else begin
      eff_count = register_count;
    end
  end
  assign frame_len = 8'd5 + {1'b0, eff_count, 1'b0};

  // A start byte restarts position, CRC and error state before it is used.
  assign pos       = frame_start ? 7'd0 : byte_position;
  assign crc_cur   = frame_start ? CRC_INIT : running_crc;
  assign err_cur   = frame_start ? ST_OK : first_error;
  assign pos_plus1 = {1'b0, pos} + 8'd1;
  assign pos_plus2 = {1'b0, pos} + 8'd2;
  assign word_slot = (pos - 7'd4) >> 1;
  assign rx_crc    = {rx_byte, held_byte};

  // Status of a closing byte: the first error found, else the CRC check.
  always_comb begin
    if (err_cur != ST_OK) begin
      close_status = err_cur;
    end else if (rx_crc != crc_cur) begin
      close_status = ST_BAD_CRC;
    end else begin
      close_status = ST_OK;
    end
  end

  // Sequencer, per-byte update and output register loading.
  always_comb begin
    state_next         = state;
    in_frame_next      = in_frame;
    byte_position_next = byte_position;
    running_crc_next   = running_crc;
    first_error_next   = first_error;
    held_byte_next     = held_byte;
    final_status_next  = final_status;
    run_count_next     = run_count;
    word_ptr_next      = word_ptr;
    out_valid_next     = out_valid && out_stall;
    check_status_next  = check_status;
    word_index_next    = word_index;
    word_value_next    = word_value;
    last_result_next   = last_result;
    store_we           = 1'b0;
    store_waddr        = AW'(word_slot);
    store_wdata        = {held_byte, rx_byte};
    store_raddr        = AW'(word_ptr);

    unique case (state)
      S_IDLE: begin
        if (accept && (frame_start || in_frame)) begin
          in_frame_next    = 1'b1;
          running_crc_next = crc_cur;
          first_error_next = err_cur;
          if (pos_plus1 >= frame_len) begin
            // Closing byte: end the frame and start the result run.
            in_frame_next      = 1'b0;
            byte_position_next = 7'd0;
            final_status_next  = close_status;
            run_count_next     = eff_count;
            word_ptr_next      = 6'd0;
            state_next         = (close_status != ST_OK) ? S_ERR : S_READ;
          end else begin
            byte_position_next = pos + 7'd1;
            if (pos_plus2 == frame_len) begin
              // Low CRC byte is held for the closing compare.
              held_byte_next = rx_byte;
            end else begin
              running_crc_next = crc_feed(crc_cur, rx_byte);
              if (pos == 7'd0) begin
                if (rx_byte != device_address && err_cur == ST_OK) begin
                  first_error_next = ST_BAD_ADDR;
                end
              end else if (pos == 7'd1) begin
                if (rx_byte != read_function_code && err_cur == ST_OK) begin
                  first_error_next = ST_BAD_FUNC;
                end
              end else if (pos == 7'd2) begin
                if (rx_byte != {1'b0, eff_count, 1'b0} && err_cur == ST_OK) begin
                  first_error_next = ST_BAD_COUNT;
                end
              end else if (pos[0]) begin
                // High byte of a data word.
                held_byte_next = rx_byte;
              end else if ({1'b0, word_slot} < 8'(MAX_REGS)) begin
                store_we = 1'b1;
              end
            end
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          out_valid_next    = 1'b1;
          check_status_next = final_status;
          word_index_next   = 5'd0;
          word_value_next   = 16'd0;
          last_result_next  = 1'b1;
          state_next        = S_IDLE;
        end
      end
      S_READ: begin
        // The store read address is word_ptr; data appears next cycle.
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (slot_free) begin
          out_valid_next    = 1'b1;
          check_status_next = ST_OK;
          word_index_next   = word_ptr[4:0];
          word_value_next   = store_rdata;
          last_result_next  = (word_ptr + 6'd1 == run_count);
          word_ptr_next     = word_ptr + 6'd1;
          state_next        = (word_ptr + 6'd1 == run_count) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address     <= RST_DEVICE_ADDRESS;
      read_function_code <= RST_READ_FUNCTION_CODE;
      register_count     <= RST_REGISTER_COUNT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEVICE_ADDRESS:     device_address     <= cfg_data;
        REG_READ_FUNCTION_CODE: read_function_code <= cfg_data;
        REG_REGISTER_COUNT:     register_count     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Control and frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      in_frame      <= 1'b0;
      byte_position <= 7'd0;
      running_crc   <= CRC_INIT;
      first_error   <= ST_OK;
      held_byte     <= 8'd0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      in_frame      <= in_frame_next;
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      first_error   <= first_error_next;
      held_byte     <= held_byte_next;
      out_valid     <= out_valid_next;
    end
  end

  // Run bookkeeping and output payload.
  always_ff @(posedge clk) begin
    final_status <= final_status_next;
    run_count    <= run_count_next;
    word_ptr     <= word_ptr_next;
    check_status <= check_status_next;
    word_index   <= word_index_next;
    word_value   <= word_value_next;
    last_result  <= last_result_next;
  end

  // Word store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (store_we) begin
      word_store[store_waddr] <= store_wdata;
    end
    store_rdata <= word_store[store_raddr];
  end

endmodule

[sv/mrrc_checker.sv]
// Port-level checks for the Modbus read-response checker, bound to the top.
// Uses mrrc_pkg for the status codes.
module mrrc_checker
  import mrrc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  check_status,
  input logic [4:0]  word_index,
  input logic [15:0] word_value,
  input logic        last_result
);

  // A stalled word holds its place and its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(word_value) && $stable(word_index)
      && $stable(check_status) && $stable(last_result))
    else $error("stalled output word changed");

  // An error word is always a lone, final word with zero index and value.
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && check_status != ST_OK |->
      last_result && word_index == 5'd0 && word_value == 16'd0)
    else $error("error word is not a lone final word");

  // While a word run is unfinished, no input is taken.
  a_run_stalls_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && check_status == ST_OK && !last_result |-> in_stall)
    else $error("input taken during a word run");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind modbus_read_response_checker mrrc_checker u_mrrc_checker (.*);

[sim/testbench.sv]
// Self-checking testbench for the Modbus RTU read-response checker.
// Depends on mrrc_pkg and modbus_read_response_checker; a scoreboard class
// predicts each frame's result words and compares them as they leave the block.
`timescale 1ns / 100ps

module testbench
  import mrrc_pkg::*;
();

  // One result word as the block presents it.
  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  index;
    logic [15:0] value;
    logic        last;
  } result_word_t;

  // Byte-wise CRC-16 with the reflected polynomial, shifting one bit at a time.
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {8'h00, d};
    repeat (8) r = {1'b0, r[15:1]} ^ (r[0] ? CRC_POLY : 16'h0000);
    return r;
  endfunction

  // Register count as the block uses it: zero reads as one, and it is capped.
  function automatic int eff_regs(input logic [5:0] count);
    if (count == 6'd0) return 1;
    if (count > DEF_MAX_REGS) return DEF_MAX_REGS;
    return int'(count);
  endfunction

  class response_scoreboard;
    // Copy of the configuration registers.
    logic [7:0]   dev_addr;
    logic [7:0]   func_code;
    logic [5:0]   reg_count;
    // Copy of the frame state.
    logic         in_frame;
    logic [6:0]   pos;
    logic [15:0]  crc;
    logic [2:0]   first_err;
    logic [7:0]   held;
    logic [15:0]  words [DEF_MAX_REGS];
    result_word_t pending_words[$];
    int           mismatches;

    function new();
      dev_addr   = RST_DEVICE_ADDRESS;
      func_code  = RST_READ_FUNCTION_CODE;
      reg_count  = RST_REGISTER_COUNT;
      in_frame   = 1'b0;
      pos        = 7'd0;
      crc        = CRC_INIT;
      first_err  = ST_OK;
      held       = 8'd0;
      mismatches = 0;
      foreach (words[i]) words[i] = 16'd0;
    endfunction

    // Only the first error of a frame is kept.
    function void flag(input logic [2:0] code);
      if (first_err == ST_OK) first_err = code;
    endfunction

    // Takes one accepted byte and queues the result words it causes.
    function void absorb_byte(input logic [7:0] b, input logic start);
      int n;
      int len;
      int p;
      int k;
      result_word_t w;
      n = eff_regs(reg_count);
      len = 5 + 2 * n;
      if (start) begin
        in_frame = 1'b1;
        pos = 7'd0;
        crc = CRC_INIT;
        first_err = ST_OK;
      end else if (!in_frame) begin
        return;
      end
      p = pos;
      // The closing byte: compare the CRC and give the error or the word run.
      if (p + 1 >= len) begin
        if ({b, held} != crc) flag(ST_BAD_CRC);
        if (first_err != ST_OK) begin
          w.status = first_err;
          w.index = 5'd0;
          w.value = 16'd0;
          w.last = 1'b1;
          pending_words.push_back(w);
        end else begin
          for (k = 0; k < n; k++) begin
            w.status = ST_OK;
            w.index = 5'(k);
            w.value = words[k];
            w.last = (k == n - 1);
            pending_words.push_back(w);
          end
        end
        in_frame = 1'b0;
        pos = 7'd0;
        return;
      end
      // The low CRC byte is held aside; everything before it feeds the CRC.
      if (p + 2 == len) begin
        held = b;
      end else begin
        crc = crc16_byte(crc, b);
        if (p == 0) begin
          if (b != dev_addr) flag(ST_BAD_ADDR);
        end else if (p == 1) begin
          if (b != func_code) flag(ST_BAD_FUNC);
        end else if (p == 2) begin
          if (b != 8'(2 * n)) flag(ST_BAD_COUNT);
        end else if (((p - 3) % 2) == 0) begin
          held = b;
        end else if ((p - 4) / 2 < DEF_MAX_REGS) begin
          words[(p - 4) / 2] = {held, b};
        end
      end
      pos = 7'(p + 1);
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task compare_field(input string name, input int got, input int want);
      if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Checks one accepted result word against the oldest prediction.
    task check_word(input logic [2:0] status, input logic [4:0] index,
                    input logic [15:0] value, input logic last);
      result_word_t w;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word status %0d index %0d value %h",
                                  status, index, value));
      end else begin
        w = pending_words.pop_front();
        compare_field("check_status", status, w.status);
        compare_field("word_index", index, w.index);
        compare_field("word_value", value, w.value);
        compare_field("last_result", last, w.last);
      end
    endtask
  endclass

  localparam int QUIET_LIMIT = 2000;

  // Bits of a frame flaw mask.
  localparam int FLAW_ADDR  = 0;
  localparam int FLAW_FUNC  = 1;
  localparam int FLAW_COUNT = 2;
  localparam int FLAW_CRC   = 3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_DEVICE_ADDRESS;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'd0;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  check_status;
  logic [4:0]  word_index;
  logic [15:0] word_value;
  logic        last_result;

  int send_idle_pct = 11;
  int stall_pct = 73;
  int quiet_cycles = 0;

  response_scoreboard sb;

  modbus_read_response_checker u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .frame_start  (frame_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .check_status (check_status),
    .word_index   (word_index),
    .word_value   (word_value),
    .last_result  (last_result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Random back-pressure on the result side.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Every accepted result word goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_word(check_status, word_index, word_value, last_result);
    end
  end

  // The run is abandoned when neither channel moves a byte or a word for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Writes all three registers on consecutive cycles.
  task automatic set_config(input logic [7:0] addr, input logic [7:0] func,
                            input logic [5:0] count);
    cfg_write <= 1'b1;
    cfg_index <= REG_DEVICE_ADDRESS;
    cfg_data <= addr;
    @(posedge clk);
    cfg_index <= REG_READ_FUNCTION_CODE;
    cfg_data <= func;
    @(posedge clk);
    cfg_index <= REG_REGISTER_COUNT;
    cfg_data <= {2'b00, count};
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.dev_addr = addr;
    sb.func_code = func;
    sb.reg_count = count;
  endtask

  // Holds the sender until every predicted word has come out, then waits a little.
  task automatic drain_results(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_words.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Offers one byte, with random gaps before it, and waits for it to be taken.
  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    frame_start <= start;
    do @(posedge clk); while (in_stall);
    sb.absorb_byte(b, start);
  endtask

  // Builds a frame for the current setting with the given flaws and sends its
  // first keep bytes. A negative fill gives random data bytes.
  task automatic send_frame(input logic [3:0] flaws, input int keep, input int fill);
    logic [7:0]  f[$];
    logic [15:0] c;
    int          n;
    int          i;
    n = eff_regs(sb.reg_count);
    f.push_back(flaws[FLAW_ADDR] ? sb.dev_addr ^ 8'($urandom_range(1, 255)) : sb.dev_addr);
    f.push_back(flaws[FLAW_FUNC] ? sb.func_code ^ 8'($urandom_range(1, 255)) : sb.func_code);
    f.push_back(flaws[FLAW_COUNT] ? 8'(2 * n) ^ 8'($urandom_range(1, 255)) : 8'(2 * n));
    repeat (2 * n) f.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    c = CRC_INIT;
    foreach (f[j]) c = crc16_byte(c, f[j]);
    if (flaws[FLAW_CRC]) c = c ^ 16'($urandom_range(1, 65535));
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
    for (i = 0; i < keep && i < f.size(); i++) send_byte(f[i], i == 0);
  endtask

  initial begin
    int ph;
    int budget;
    int sent;
    int pick;
    int len;
    int cut;

    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part: a zero count reads as one register, so frames are short.
    set_config(8'h00, 8'hFF, 6'd0);
    send_byte(8'h5A, 1'b0);
    send_frame(4'b0000, 7, 8'hFF);
    send_frame(4'b1111, 7, -1);
    // A new start cuts the first frame short; the second has zero data and a bad CRC.
    send_frame(4'b0000, 3, -1);
    send_frame(4'b1 << FLAW_CRC, 7, 8'h00);
    // Count lowered while a frame is open: the next byte closes it.
    drain_results(4);
    set_config(8'h00, 8'hFF, 6'd2);
    send_frame(4'b0000, 6, -1);
    drain_results(4);
    set_config(8'h00, 8'hFF, 6'd1);
    send_byte(8'($urandom), 1'b0);

    // Random part, one setting per phase.
    for (ph = 0; ph < 6; ph++) begin
      drain_results(4);
      if (ph < 2) begin
        send_idle_pct = 11;
        stall_pct = 73;
      end else if (ph < 4) begin
        send_idle_pct = 73;
        stall_pct = 11;
      end else begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      case (ph)
        0: begin
          set_config(8'h01, 8'h03, 6'd1);
          budget = 35;
        end
        1: begin
          set_config(8'hFF, 8'h00, 6'd3);
          budget = 35;
        end
        2: begin
          set_config(8'($urandom), 8'($urandom), 6'd32);
          budget = 40;
        end
        3: begin
          set_config(8'($urandom), 8'($urandom), 6'd63);
          budget = 40;
        end
        4: begin
          set_config(8'($urandom), 8'($urandom), 6'($urandom_range(1, 6)));
          budget = 45;
        end
        default: begin
          set_config(8'($urandom), RST_READ_FUNCTION_CODE, 6'd2);
          budget = 35;
        end
      endcase

      sent = 0;
      while (sent < budget) begin
        pick = $urandom_range(99);
        len = 5 + 2 * eff_regs(sb.reg_count);
        if (pick < 70) begin
          send_frame(4'b0000, len, -1);
          sent += len;
        end else if (pick < 85) begin
          send_frame(4'($urandom_range(1, 15)), len, -1);
          sent += len;
        end else if (pick < 92) begin
          // A broken frame, always followed by a whole one.
          cut = $urandom_range(1, len - 1);
          send_frame(4'($urandom), cut, -1);
          send_frame(4'b0000, len, -1);
          sent += cut + len;
        end else if (pick < 97) begin
          // Bytes between frames, which the block ignores.
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
        end else begin
          drain_results(0);
        end
      end
    end

    drain_results(2 * DEF_MAX_REGS + 8);
    if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
sv/mrrc_pkg.sv
sv/modbus_read_response_checker.sv
sv/mrrc_checker.sv
sim/testbench.sv
